>>> rtl/bf_pkg.sv
// Shared types and constants for the Blowfish block cipher pipeline.
// No dependencies; used by blowfish_block_cipher_top and bf_round.
package bf_pkg;

	localparam int ROUNDS_DEF   = 16;
	localparam int SUBKEY_COUNT = 18;
	localparam int SBOX_DEPTH   = 256;
	localparam int SBOX_COUNT   = 4;
	localparam int IDX_W        = 10;
	localparam int WORD_W       = 32;
	localparam int BLOCK_W      = 64;

	typedef enum logic [1:0] {
		OP_WR_KEY  = 2'd0,
		OP_WR_SBOX = 2'd1,
		OP_ENC     = 2'd2,
		OP_DEC     = 2'd3
	} bf_op_t;

	// One word as it travels down the pipeline: writes and blocks alike.
	typedef struct packed {
		bf_op_t              op;
		logic [IDX_W-1:0]    idx;
		logic [WORD_W-1:0]   word;
		logic [WORD_W-1:0]   hi;
		logic [WORD_W-1:0]   lo;
	} bf_item_t;

endpackage

>>> rtl/blowfish_block_cipher_top.sv
// Top level of the Blowfish 64-bit block cipher in electronic codebook mode.
// Depends on bf_pkg, bf_round and bf_ram.
//
// In every cycle that the pipeline is not held, the block takes one word: a
// subkey write, an S-box write, or a block to encrypt or decrypt; a block passes
// the round stages and then the output register, one block per cycle sustained.
// Each round owns two pipeline stages: the first mixes in the subkey and
// reads four 256-word S-box RAMs, the second applies the round function.
// Every round holds its own copy of the S-boxes and of the subkeys it uses,
// and writes travel down the pipeline so that each copy is updated in the
// same order as blocks pass it. Writes yield no result. Throughput is set by
// the downstream ready alone: the whole pipeline holds while a finished
// block waits in the output register.
module blowfish_block_cipher_top #(
	parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [bf_pkg::IDX_W-1:0]     table_index,
	input  logic [bf_pkg::WORD_W-1:0]    table_word,
	input  logic [bf_pkg::BLOCK_W-1:0]   block_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bf_pkg::BLOCK_W-1:0]   block_out,
	output logic                         was_decrypt
);
	import bf_pkg::*;

	localparam logic [IDX_W-1:0] K0_IDX  = IDX_W'(0);
	localparam logic [IDX_W-1:0] K1_IDX  = IDX_W'(1);
	localparam logic [IDX_W-1:0] KR_IDX  = IDX_W'(ROUNDS);
	localparam logic [IDX_W-1:0] KR1_IDX = IDX_W'(ROUNDS + 1);

	logic              adv;
	logic              ch_valid [ROUNDS+1];
	bf_item_t          ch_item  [ROUNDS+1];
	bf_item_t          last;
	logic              last_valid;
	logic              wr_key;
	logic [WORD_W-1:0] k0_q;
	logic [WORD_W-1:0] k1_q;
	logic [WORD_W-1:0] kr_q;
	logic [WORD_W-1:0] kr1_q;
	logic              out_valid_q;
	logic [BLOCK_W-1:0] block_out_q;
	logic              was_decrypt_q;

	// The pipeline moves whenever the output register is free or being read.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	assign ch_valid[0]     = in_valid;
	assign ch_item[0].op   = bf_op_t'(op);
	assign ch_item[0].idx  = table_index;
	assign ch_item[0].word = table_word;
	assign ch_item[0].hi   = block_in[BLOCK_W-1:WORD_W];
	assign ch_item[0].lo   = block_in[WORD_W-1:0];

	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		bf_round #(
			.ROUNDS (ROUNDS),
			.RND    (r)
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (ch_valid[r]),
			.in_item   (ch_item[r]),
			.out_valid (ch_valid[r+1]),
			.out_item  (ch_item[r+1])
		);
	end

	assign last       = ch_item[ROUNDS];
	assign last_valid = ch_valid[ROUNDS];
	assign wr_key     = adv && last_valid && (last.op == OP_WR_KEY);

	// Output whitening subkeys, kept in order with the blocks reaching them.
	always_ff @(posedge clk) begin
		if (wr_key && (last.idx == K0_IDX)) begin
			k0_q <= last.word;
		end
		if (wr_key && (last.idx == K1_IDX)) begin
			k1_q <= last.word;
		end
		if (wr_key && (last.idx == KR_IDX)) begin
			kr_q <= last.word;
		end
		if (wr_key && (last.idx == KR1_IDX)) begin
			kr1_q <= last.word;
		end
	end

	// Output register: undo the last swap and apply the whitening subkeys.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last_valid && last.op[1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			was_decrypt_q <= (last.op == OP_DEC);
			if (last.op == OP_DEC) begin
				block_out_q <= {last.lo ^ k0_q, last.hi ^ k1_q};
			end else begin
				block_out_q <= {last.lo ^ kr1_q, last.hi ^ kr_q};
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign block_out   = block_out_q;
	assign was_decrypt = was_decrypt_q;

	// A write reaching the end never becomes a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_valid && !last.op[1]) |=> !out_valid)
		else $error("write word produced a result");

	// A held result freezes the whole pipeline, last stage included.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(last_valid) && $stable(last)))
		else $error("pipeline moved while output stalled");

	// The input side is closed exactly while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted during output stall");

endmodule

>>> rtl/bf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bf_round.sv
// One Feistel round in two pipeline stages, with its own S-box and subkey copies.
// Depends on bf_pkg and bf_ram.
module bf_round #(
	parameter int ROUNDS = bf_pkg::ROUNDS_DEF,
	parameter int RND    = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  bf_pkg::bf_item_t in_item,
	output logic             out_valid,
	output bf_pkg::bf_item_t out_item
);
	import bf_pkg::*;

	localparam int SB_AW = $clog2(SBOX_DEPTH);
	localparam logic [IDX_W-1:0] ENC_IDX = IDX_W'(RND);
	localparam logic [IDX_W-1:0] DEC_IDX = IDX_W'(ROUNDS + 1 - RND);

	logic [WORD_W-1:0] key_enc_q;
	logic [WORD_W-1:0] key_dec_q;
	logic [WORD_W-1:0] hx;
	logic [WORD_W-1:0] sb_rd [SBOX_COUNT];
	logic [WORD_W-1:0] f_val;
	logic              wr_key;
	logic              wr_sbox;
	logic              valid_s1;
	bf_item_t          item_s1;
	logic              valid_s2;
	bf_item_t          item_s2;

	assign wr_key  = adv && in_valid && (in_item.op == OP_WR_KEY);
	assign wr_sbox = adv && in_valid && (in_item.op == OP_WR_SBOX);

	// This round's subkey copies follow writes in pipeline order.
	always_ff @(posedge clk) begin
		if (wr_key && (in_item.idx == ENC_IDX)) begin
			key_enc_q <= in_item.word;
		end
		if (wr_key && (in_item.idx == DEC_IDX)) begin
			key_dec_q <= in_item.word;
		end
	end

	// Left half after the subkey; its bytes address the S-boxes.
	assign hx = in_item.hi ^ ((in_item.op == OP_DEC) ? key_dec_q : key_enc_q);

	for (genvar n = 0; n < SBOX_COUNT; n++) begin : g_sbox
		bf_ram #(
			.WIDTH (WORD_W),
			.DEPTH (SBOX_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_sbox && (in_item.idx[IDX_W-1:SB_AW] == 2'(n))),
			.waddr (in_item.idx[SB_AW-1:0]),
			.wdata (in_item.word),
			.re    (adv),
			.raddr (hx[8*(SBOX_COUNT-1-n) +: 8]),
			.rdata (sb_rd[n])
		);
	end

	// First stage: key mixed into the left half while the S-boxes are read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= in_item;
			item_s1.hi <= hx;
		end
	end

	// Round function from the four S-box words.
	assign f_val = ((sb_rd[0] + sb_rd[1]) ^ sb_rd[2]) + sb_rd[3];

	// Second stage: fold into the right half and swap the halves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2    <= item_s1;
			item_s2.hi <= item_s1.lo ^ f_val;
			item_s2.lo <= item_s1.hi;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Blowfish block cipher top level.
// Depends on bf_pkg and blowfish_block_cipher_top; holds its own cipher predictor.
// Loads all tables, runs directed and random words with random stalls on both sides.

class cipher_scoreboard;
	typedef struct {
		logic [63:0] blk;
		logic        dec;
	} cipher_result_t;

	logic [31:0] subkeys[bf_pkg::SUBKEY_COUNT];
	logic [31:0] sbox[bf_pkg::SBOX_COUNT * bf_pkg::SBOX_DEPTH];
	cipher_result_t expected_q[$];
	int errors;
	int checked;
	int n_enc;
	int n_dec;
	int n_wr;

	function new();
		errors = 0;
		checked = 0;
		n_enc = 0;
		n_dec = 0;
		n_wr = 0;
	endfunction

	// The round function: four S-box lookups combined by add, xor, add.
	function logic [31:0] feistel(logic [31:0] v);
		logic [31:0] f;
		f = sbox[{2'd0, v[31:24]}] + sbox[{2'd1, v[23:16]}];
		f = f ^ sbox[{2'd2, v[15:8]}];
		return f + sbox[{2'd3, v[7:0]}];
	endfunction

	function logic [63:0] run_cipher(logic [63:0] blk, logic dec);
		logic [31:0] h;
		logic [31:0] l;
		logic [31:0] t;
		int r;
		h = blk[63:32];
		l = blk[31:0];
		for (r = 0; r < bf_pkg::ROUNDS_DEF; r++) begin
			h = h ^ (dec ? subkeys[bf_pkg::ROUNDS_DEF + 1 - r] : subkeys[r]);
			l = l ^ feistel(h);
			t = h;
			h = l;
			l = t;
		end
		// Undo the last swap, then whiten with the two outer subkeys.
		t = h;
		h = l;
		l = t;
		if (dec) begin
			l = l ^ subkeys[1];
			h = h ^ subkeys[0];
		end else begin
			l = l ^ subkeys[bf_pkg::ROUNDS_DEF];
			h = h ^ subkeys[bf_pkg::ROUNDS_DEF + 1];
		end
		return {h, l};
	endfunction

	// Note an accepted input word: update the tables or queue a result.
	function void note_input(bf_pkg::bf_op_t op, logic [9:0] idx, logic [31:0] wd,
			logic [63:0] blk);
		cipher_result_t e;
		case (op)
			bf_pkg::OP_WR_KEY: begin
				if (idx < bf_pkg::SUBKEY_COUNT)
					subkeys[idx] = wd;
				n_wr++;
			end
			bf_pkg::OP_WR_SBOX: begin
				sbox[idx] = wd;
				n_wr++;
			end
			bf_pkg::OP_ENC: begin
				e.blk = run_cipher(blk, 1'b0);
				e.dec = 1'b0;
				expected_q.push_back(e);
				n_enc++;
			end
			default: begin
				e.blk = run_cipher(blk, 1'b1);
				e.dec = 1'b1;
				expected_q.push_back(e);
				n_dec++;
			end
		endcase
	endfunction

	// Compare one accepted result with the oldest expectation.
	function void check_result(logic [63:0] blk, logic dec);
		cipher_result_t e;
		if (expected_q.size() == 0) begin
			$error("unexpected result block_out=%h was_decrypt=%b", blk, dec);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (blk !== e.blk) begin
			$error("block_out mismatch: expected %h, actual %h", e.blk, blk);
			errors++;
		end
		if (dec !== e.dec) begin
			$error("was_decrypt mismatch: expected %b, actual %b", e.dec, dec);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 650;
	localparam int CALM_WORDS   = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [9:0]  table_index;
	logic [31:0] table_word;
	logic [63:0] block_in;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] block_out;
	logic        was_decrypt;

	cipher_scoreboard sb;
	bit calm;
	bit hold_req;
	int idle_cycles = 0;

	blowfish_block_cipher_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.table_index (table_index),
		.table_word  (table_word),
		.block_in    (block_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.block_out   (block_out),
		.was_decrypt (was_decrypt)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Offer one word and wait for it to be accepted; optionally idle afterwards.
	task automatic send_word(bf_pkg::bf_op_t o, logic [9:0] idx, logic [31:0] wd,
			logic [63:0] blk);
		int gap;
		in_valid <= 1'b1;
		op <= o;
		table_index <= idx;
		table_word <= wd;
		block_in <= blk;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(o, idx, wd, blk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [63:0] rand_block();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return {64{1'b1}};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(block_out, was_decrypt);
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[blowfish_block_cipher_top] ERROR");
			$finish;
		end
	end

	// Receiver: random ready bursts, one long hold-off, steady at the end.
	initial begin
		bit hold_done;
		int n;
		hold_done = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				n = $urandom_range(1, 20);
				out_ready <= 1'b1;
				repeat (n) @(posedge clk);
				if ($urandom_range(0, 1) == 0) begin
					n = $urandom_range(1, 15);
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Sender: table load, directed words, random words, then drain.
	initial begin
		bf_pkg::bf_op_t o;
		int i;
		int k;
		sb = new();
		calm = 0;
		hold_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = bf_pkg::OP_WR_KEY;
		table_index = '0;
		table_word = '0;
		block_in = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every table entry is written before any block is ciphered.
		for (i = 0; i < bf_pkg::SUBKEY_COUNT; i++)
			send_word(bf_pkg::OP_WR_KEY, i[9:0], rand_word(), rand_block());
		for (i = 0; i < bf_pkg::SBOX_COUNT * bf_pkg::SBOX_DEPTH; i++)
			send_word(bf_pkg::OP_WR_SBOX, i[9:0], rand_word(), rand_block());

		// Directed: extreme blocks both ways, out-of-range subkey writes.
		send_word(bf_pkg::OP_ENC, 10'h3FF, 32'hFFFF_FFFF, 64'h0);
		send_word(bf_pkg::OP_DEC, 10'h3FF, 32'hFFFF_FFFF, 64'h0);
		send_word(bf_pkg::OP_ENC, 10'h0, 32'h0, {64{1'b1}});
		send_word(bf_pkg::OP_DEC, 10'h0, 32'h0, {64{1'b1}});
		send_word(bf_pkg::OP_WR_KEY, 10'd18, 32'hDEAD_BEEF, {64{1'b1}});
		send_word(bf_pkg::OP_WR_KEY, 10'h3FF, 32'hFFFF_FFFF, {64{1'b1}});
		send_word(bf_pkg::OP_ENC, 10'h0, 32'h0, 64'h0123_4567_89AB_CDEF);
		send_word(bf_pkg::OP_WR_KEY, 10'd0, 32'hFFFF_FFFF, 64'h0);
		send_word(bf_pkg::OP_WR_KEY, 10'd17, 32'h0, 64'h0);
		send_word(bf_pkg::OP_WR_SBOX, 10'h3FF, 32'hFFFF_FFFF, 64'h0);
		send_word(bf_pkg::OP_WR_SBOX, 10'h0, 32'h0, 64'h0);
		send_word(bf_pkg::OP_ENC, 10'h0, 32'h0, {64{1'b1}});
		send_word(bf_pkg::OP_DEC, 10'h0, 32'h0, 64'h8000_0000_0000_0001);
		send_word(bf_pkg::OP_ENC, 10'h0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFE);

		// Sender pause until every pending result has come back.
		wait_drained();

		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == 100)
				hold_req = 1;
			if (k == 400)
				wait_drained();
			if (k == RANDOM_WORDS - CALM_WORDS)
				calm = 1;
			i = $urandom_range(0, 99);
			if (i < 70) begin
				o = ($urandom_range(0, 1) == 0) ? bf_pkg::OP_ENC : bf_pkg::OP_DEC;
				send_word(o, 10'($urandom()), $urandom(), rand_block());
			end else if (i < 88) begin
				send_word(bf_pkg::OP_WR_SBOX, 10'($urandom()), rand_word(),
					rand_block());
			end else if (i < 95) begin
				send_word(bf_pkg::OP_WR_KEY, 10'($urandom_range(0, 17)), rand_word(),
					rand_block());
			end else begin
				send_word(bf_pkg::OP_WR_KEY, 10'($urandom_range(18, 1023)), rand_word(),
					rand_block());
			end
		end

		// Drain, then allow the pipeline latency to pass.
		wait_drained();
		repeat (2 * bf_pkg::ROUNDS_DEF + 8) @(posedge clk);
		$display("Covered %0d table writes, %0d encrypts and %0d decrypts;",
			sb.n_wr, sb.n_enc, sb.n_dec);
		$display("%0d results checked with stalls on both sides.", sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[blowfish_block_cipher_top] OK");
		end else begin
			$display("[blowfish_block_cipher_top] ERROR");
		end
		$finish;
	end
endmodule
